>>> hw/rtl/tseq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tseq_pkg;

	localparam int unsigned CODE_W = 3;
	localparam int unsigned AGENT_W = 8;
	localparam int unsigned SEC_W = 32;
	localparam int unsigned NSEC_W = 30;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [AGENT_W-1:0] agent;
		logic [SEC_W-1:0]   sec;
		logic [NSEC_W-1:0]  nsec;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		KIND_ACCEPTED = 2'd0,
		KIND_FULL     = 2'd1,
		KIND_ENTRY    = 2'd2,
		KIND_EMPTY    = 2'd3
	} kind_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_DRAIN  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INS,
		ST_PUT,
		ST_DRAIN
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/tseq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tseq_ram #(
	parameter int unsigned WIDTH = 73,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/tseq_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module tseq_cmp
	import tseq_pkg::*;
(
	input  wire entry_t stored,
	input  wire entry_t probe,
	output logic        not_earlier
);

	// Seconds and nanoseconds concatenate into one key that orders like the time.
	assign not_earlier = {stored.sec, stored.nsec} >= {probe.sec, probe.nsec};

endmodule

`default_nettype wire

>>> hw/rtl/time_sorted_event_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Insert: when the queue is empty or full, the result is registered and shows in the cycle
// after accept; otherwise the scan walks back from the tail one entry per cycle.
// Drain: one entry per cycle, the first result passing the RAM read and output registers.
// Busy stays high through the scan of an insert and through a drain, so the next item is
// taken in the cycle its last result shows; other items go one per cycle.
// Reset empties the queue; the receiver cannot stall.
module time_sorted_event_queue_core
	import tseq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                action,
	input  wire logic [CODE_W-1:0]   event_code,
	input  wire logic [AGENT_W-1:0]  src_agent,
	input  wire logic [SEC_W-1:0]    time_seconds,
	input  wire logic [NSEC_W-1:0]   time_nanosec,
	output logic                     done,
	output logic [1:0]               kind,
	output logic [CODE_W-1:0]        out_event_code,
	output logic [AGENT_W-1:0]       out_agent,
	output logic [SEC_W-1:0]         out_seconds,
	output logic [NSEC_W-1:0]        out_nanosec,
	output logic                     last
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [AW-1:0]   idx_q, idx_d;
	entry_t          new_q;
	logic [CW-1:0]   count_m1;

	logic            we;
	logic [AW-1:0]   waddr, raddr;
	entry_t          wdata, rdata;
	logic            ge;

	logic            res_valid;
	kind_t           res_kind;
	entry_t          res_data;
	logic            res_last;

	logic            accept;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign count_m1 = count_q - CW'(1);

	tseq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	tseq_cmp u_cmp (
		.stored     (rdata),
		.probe      (new_q),
		.not_earlier(ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done    <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (accept) begin
			new_q <= '{code: event_code, agent: src_agent, sec: time_seconds,
				nsec: time_nanosec};
		end
		if (res_valid) begin
			kind           <= res_kind;
			out_event_code <= res_data.code;
			out_agent      <= res_data.agent;
			out_seconds    <= res_data.sec;
			out_nanosec    <= res_data.nsec;
			last           <= res_last;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		we        = 1'b0;
		waddr     = '0;
		wdata     = new_q;
		raddr     = '0;
		res_valid = 1'b0;
		res_kind  = KIND_ACCEPTED;
		res_data  = '0;
		res_last  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_INSERT) begin
						if (count_q == CW'(QUEUE_DEPTH)) begin
							res_valid = 1'b1;
							res_kind  = KIND_FULL;
						end else if (count_q == '0) begin
							we    = 1'b1;
							waddr = '0;
							wdata = '{code: event_code, agent: src_agent,
								sec: time_seconds, nsec: time_nanosec};
							count_d   = count_q + CW'(1);
							res_valid = 1'b1;
						end else begin
							raddr   = count_m1[AW-1:0];
							idx_d   = count_m1[AW-1:0];
							state_d = ST_INS;
						end
					end else begin
						if (count_q == '0) begin
							res_valid = 1'b1;
							res_kind  = KIND_EMPTY;
						end else begin
							raddr   = '0;
							idx_d   = '0;
							state_d = ST_DRAIN;
						end
					end
				end
			end
			ST_INS: begin
				// rdata holds entry idx_q; later entries move down one slot.
				we    = 1'b1;
				waddr = idx_q + AW'(1);
				if (ge) begin
					wdata = rdata;
					if (idx_q == '0) begin
						state_d = ST_PUT;
					end else begin
						raddr = idx_q - AW'(1);
						idx_d = idx_q - AW'(1);
					end
				end else begin
					wdata     = new_q;
					count_d   = count_q + CW'(1);
					res_valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_PUT: begin
				we        = 1'b1;
				waddr     = '0;
				wdata     = new_q;
				count_d   = count_q + CW'(1);
				res_valid = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_DRAIN: begin
				res_valid = 1'b1;
				res_kind  = KIND_ENTRY;
				res_data  = rdata;
				res_last  = (idx_q == count_m1[AW-1:0]);
				if (res_last) begin
					count_d = '0;
					state_d = ST_IDLE;
				end else begin
					raddr = idx_q + AW'(1);
					idx_d = idx_q + AW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count exceeds queue depth");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_INSERT && count_q == CW'(QUEUE_DEPTH))
		|=> (done && kind == KIND_FULL && last))
		else $error("insert into full queue not refused");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last) |-> (state_q == ST_IDLE))
		else $error("final result while sequencer still active");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(done && kind == KIND_ENTRY && last) |-> (count_q == '0))
		else $error("queue not empty after drain");
`endif

endmodule

`default_nettype wire
